### src/bepq_pkg.sv
// Shared types, constants and codes for the bucketed event priority queue.
package bepq_pkg;

    localparam int CAPACITY    = 256;
    localparam int MAX_BUCKETS = 64;
    localparam int HANDLE_W    = 8;
    localparam int PTR_W       = HANDLE_W + 1;
    localparam int BKT_W       = 6;
    localparam int CNT_W       = 9;
    localparam int KEY_W       = 32;
    localparam int SPAN_W      = 31;
    localparam int BC_W        = 7;
    localparam int CFG_W       = 32;
    localparam int PROD_W      = SPAN_W + BC_W;
    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(CAPACITY);

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_PEEK    = 2'd2,
        REQ_EXTRACT = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_Y_ORIGIN     = 2'd0,
        CFG_Y_SPAN       = 2'd1,
        CFG_BUCKET_COUNT = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_H,
        S_BK_MUL,
        S_BK_DIV,
        S_HEAD_RD,
        S_HEAD_USE,
        S_NODE_RD,
        S_NODE_CMP,
        S_INS_WR,
        S_INS_LINK,
        S_REM_UNLINK,
        S_ADV_CLAMP,
        S_ADV_STEP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    latch_req;
        logic    bk_mul;
        logic    bk_div;
        logic    head_rd;
        logic    cur_from_head;
        logic    node_rd_cur;
        logic    node_rd_handle;
        logic    step;
        logic    min_take;
        logic    ins_write;
        logic    ins_link;
        logic    rem_unlink;
        logic    adv_clamp;
        logic    adv_step;
        logic    out_load;
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        req_t             req;
        logic             present_h;
        logic             full;
        logic             live_zero;
        logic             bk_direct;
        logic             div_last;
        logic             head_ne;
        logic             key_greater;
        logic             cur_is_h;
        logic             next_nil;
        logic             prev_nil;
        logic             adv_done;
        logic             out_free;
        logic [CNT_W-1:0] live;
    } sts_t;

endpackage

### src/bepq_ctrl.sv
// Request sequencer of the bucketed event priority queue.
module bepq_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  bepq_pkg::sts_t sts,
    output bepq_pkg::cmd_t cmd
);

    bepq_pkg::state_t  state_reg, state_next;
    bepq_pkg::status_t status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bepq_pkg::S_IDLE;
            status_reg <= bepq_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            bepq_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = bepq_pkg::S_DECODE;
            end
            bepq_pkg::S_DECODE:
            begin
                unique case (sts.req)
                    bepq_pkg::REQ_INSERT:
                    begin
                        if (sts.present_h || sts.full)
                        begin
                            status_next = bepq_pkg::ST_FULL;
                            state_next  = bepq_pkg::S_FINISH;
                        end
                        else
                            state_next = bepq_pkg::S_BK_MUL;
                    end
                    bepq_pkg::REQ_REMOVE:
                    begin
                        if (!sts.present_h)
                        begin
                            status_next = bepq_pkg::ST_ABSENT;
                            state_next  = bepq_pkg::S_FINISH;
                        end
                        else
                            state_next = bepq_pkg::S_RD_H;
                    end
                    bepq_pkg::REQ_PEEK, bepq_pkg::REQ_EXTRACT:
                    begin
                        if (sts.live_zero)
                        begin
                            status_next = bepq_pkg::ST_EMPTY;
                            state_next  = bepq_pkg::S_FINISH;
                        end
                        else
                            state_next = bepq_pkg::S_ADV_CLAMP;
                    end
                    default: state_next = bepq_pkg::S_FINISH;
                endcase
            end
            bepq_pkg::S_RD_H:    state_next = bepq_pkg::S_BK_MUL;
            bepq_pkg::S_BK_MUL:
            begin
                state_next = sts.bk_direct ? bepq_pkg::S_HEAD_RD : bepq_pkg::S_BK_DIV;
            end
            bepq_pkg::S_BK_DIV:
            begin
                if (sts.div_last)
                    state_next = bepq_pkg::S_HEAD_RD;
            end
            bepq_pkg::S_HEAD_RD: state_next = bepq_pkg::S_HEAD_USE;
            bepq_pkg::S_HEAD_USE:
            begin
                if (sts.head_ne)
                    state_next = bepq_pkg::S_NODE_RD;
                else if (sts.req == bepq_pkg::REQ_INSERT)
                    state_next = bepq_pkg::S_INS_WR;
                else
                begin
                    status_next = (sts.req == bepq_pkg::REQ_REMOVE) ?
                                  bepq_pkg::ST_ABSENT : bepq_pkg::ST_EMPTY;
                    state_next  = bepq_pkg::S_FINISH;
                end
            end
            bepq_pkg::S_NODE_RD: state_next = bepq_pkg::S_NODE_CMP;
            bepq_pkg::S_NODE_CMP:
            begin
                unique case (sts.req)
                    bepq_pkg::REQ_INSERT:
                    begin
                        if (sts.key_greater && !sts.next_nil)
                            state_next = bepq_pkg::S_NODE_RD;
                        else
                            state_next = bepq_pkg::S_INS_WR;
                    end
                    bepq_pkg::REQ_REMOVE:
                    begin
                        if (sts.cur_is_h)
                            state_next = bepq_pkg::S_REM_UNLINK;
                        else if (sts.next_nil)
                        begin
                            status_next = bepq_pkg::ST_ABSENT;
                            state_next  = bepq_pkg::S_FINISH;
                        end
                        else
                            state_next = bepq_pkg::S_NODE_RD;
                    end
                    default:
                    begin
                        status_next = bepq_pkg::ST_OK;
                        state_next  = bepq_pkg::S_FINISH;
                    end
                endcase
            end
            bepq_pkg::S_INS_WR:
            begin
                status_next = bepq_pkg::ST_OK;
                state_next  = sts.prev_nil ? bepq_pkg::S_FINISH : bepq_pkg::S_INS_LINK;
            end
            bepq_pkg::S_INS_LINK: state_next = bepq_pkg::S_FINISH;
            bepq_pkg::S_REM_UNLINK:
            begin
                status_next = bepq_pkg::ST_OK;
                state_next  = bepq_pkg::S_FINISH;
            end
            bepq_pkg::S_ADV_CLAMP: state_next = bepq_pkg::S_ADV_STEP;
            bepq_pkg::S_ADV_STEP:
            begin
                if (sts.adv_done)
                    state_next = bepq_pkg::S_HEAD_RD;
            end
            bepq_pkg::S_FINISH:
            begin
                if (sts.out_free)
                    state_next = bepq_pkg::S_IDLE;
            end
            default: state_next = bepq_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd            = '0;
        cmd.res_status = status_reg;
        unique case (state_reg)
            bepq_pkg::S_IDLE:     cmd.latch_req = in_valid;
            bepq_pkg::S_DECODE:
            begin
                cmd.node_rd_handle = (sts.req == bepq_pkg::REQ_REMOVE);
            end
            bepq_pkg::S_BK_MUL:   cmd.bk_mul = 1'b1;
            bepq_pkg::S_BK_DIV:   cmd.bk_div = 1'b1;
            bepq_pkg::S_HEAD_RD:  cmd.head_rd = 1'b1;
            bepq_pkg::S_HEAD_USE: cmd.cur_from_head = 1'b1;
            bepq_pkg::S_NODE_RD:  cmd.node_rd_cur = 1'b1;
            bepq_pkg::S_NODE_CMP:
            begin
                unique case (sts.req)
                    bepq_pkg::REQ_INSERT: cmd.step = sts.key_greater;
                    bepq_pkg::REQ_REMOVE: cmd.step = !sts.cur_is_h;
                    default:              cmd.min_take = 1'b1;
                endcase
            end
            bepq_pkg::S_INS_WR:     cmd.ins_write = 1'b1;
            bepq_pkg::S_INS_LINK:   cmd.ins_link = 1'b1;
            bepq_pkg::S_REM_UNLINK: cmd.rem_unlink = 1'b1;
            bepq_pkg::S_ADV_CLAMP:  cmd.adv_clamp = 1'b1;
            bepq_pkg::S_ADV_STEP:   cmd.adv_step = !sts.adv_done;
            bepq_pkg::S_FINISH:     cmd.out_load = sts.out_free;
            default:                cmd.latch_req = 1'b0;
        endcase
    end

    assign in_stall = (state_reg != bepq_pkg::S_IDLE);

endmodule

### src/bepq_dp.sv
// Datapath of the bucketed event priority queue: node store, bucket heads, divider, result.
module bepq_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  bepq_pkg::cmd_t                      cmd,
    output bepq_pkg::sts_t                      sts,
    input  logic [1:0]                          req_type,
    input  logic [bepq_pkg::HANDLE_W-1:0]       handle,
    input  logic signed [bepq_pkg::KEY_W-1:0]   y_key,
    input  logic signed [bepq_pkg::KEY_W-1:0]   x_key,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [bepq_pkg::CFG_W-1:0]          cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic [bepq_pkg::HANDLE_W-1:0]       out_handle,
    output logic signed [bepq_pkg::KEY_W-1:0]   out_y,
    output logic signed [bepq_pkg::KEY_W-1:0]   out_x,
    output logic [bepq_pkg::CNT_W-1:0]          entry_count,
    output logic                                is_empty
);

    localparam int HW = bepq_pkg::HANDLE_W;
    localparam int PW = bepq_pkg::PTR_W;
    localparam int BW = bepq_pkg::BKT_W;
    localparam int KW = bepq_pkg::KEY_W;
    localparam int XW = bepq_pkg::PROD_W;

    // configuration
    logic signed [KW-1:0]           y_origin_reg;
    logic [bepq_pkg::SPAN_W-1:0]    y_span_reg;
    logic [bepq_pkg::BC_W-1:0]      bucket_count_reg;

    // request
    bepq_pkg::req_t                 req_reg;
    logic [HW-1:0]                  handle_reg;
    logic signed [KW-1:0]           y_reg, x_reg;

    // queue state
    logic [bepq_pkg::CAPACITY-1:0]    present_reg;
    logic [bepq_pkg::MAX_BUCKETS-1:0] nonempty_reg;
    logic [BW-1:0]                    lowest_reg;
    logic [bepq_pkg::CNT_W-1:0]       live_reg;

    // bucket index unit
    logic [XW-1:0]                  prod_reg, prod_next;
    logic [bepq_pkg::BC_W-1:0]      q_reg, q_next;
    logic [2:0]                     div_i_reg;
    logic [BW-1:0]                  bkt_reg;

    // list walk
    logic [PW-1:0]                  cur_reg, prev_reg;
    logic [HW-1:0]                  head_q;
    logic signed [KW-1:0]           rd_y_q, rd_x_q;
    logic [PW-1:0]                  rd_next_q;

    // result
    logic                           res_min_reg;
    logic [HW-1:0]                  res_handle_reg;
    logic signed [KW-1:0]           res_y_reg, res_x_reg;

    logic signed [KW-1:0]           node_y_mem [bepq_pkg::CAPACITY];
    logic signed [KW-1:0]           node_x_mem [bepq_pkg::CAPACITY];
    logic [PW-1:0]                  node_next_mem [bepq_pkg::CAPACITY];
    logic [HW-1:0]                  head_mem [bepq_pkg::MAX_BUCKETS];

    logic [bepq_pkg::BC_W-1:0]      n_used;
    logic [BW-1:0]                  n_last;
    logic signed [KW-1:0]           y_b;
    logic signed [KW:0]             off;
    logic                           off_neg, off_ge_span;
    logic [XW-1:0]                  span_sh;
    logic                           is_min, is_extract;
    logic [BW-1:0]                  hidx;
    logic                           next_we;
    logic [HW-1:0]                  next_waddr;
    logic [PW-1:0]                  next_wdata;
    logic [HW-1:0]                  node_raddr;
    logic                           head_we;
    logic [BW-1:0]                  head_waddr;
    logic [HW-1:0]                  head_wdata;

    always_comb
    begin
        if (bucket_count_reg == '0)
            n_used = bepq_pkg::BC_W'(1);
        else if (bucket_count_reg > bepq_pkg::BC_W'(bepq_pkg::MAX_BUCKETS))
            n_used = bepq_pkg::BC_W'(bepq_pkg::MAX_BUCKETS);
        else
            n_used = bucket_count_reg;
    end
    assign n_last = BW'(n_used - bepq_pkg::BC_W'(1));

    assign y_b         = (req_reg == bepq_pkg::REQ_REMOVE) ? rd_y_q : y_reg;
    assign off         = {y_b[KW-1], y_b} - {y_origin_reg[KW-1], y_origin_reg};
    assign off_neg     = off[KW];
    assign off_ge_span = !off_neg && (off[KW-1:0] >= {1'b0, y_span_reg});
    assign span_sh     = XW'(y_span_reg) << div_i_reg;

    // one quotient bit a cycle; the quotient stays below the bucket count
    always_comb
    begin
        prod_next = prod_reg;
        q_next    = q_reg;
        if (prod_reg >= span_sh)
        begin
            prod_next           = prod_reg - span_sh;
            q_next[div_i_reg]   = 1'b1;
        end
    end

    assign is_min     = (req_reg == bepq_pkg::REQ_PEEK) || (req_reg == bepq_pkg::REQ_EXTRACT);
    assign is_extract = (req_reg == bepq_pkg::REQ_EXTRACT);
    assign hidx       = is_min ? lowest_reg : bkt_reg;
    assign node_raddr = cmd.node_rd_handle ? handle_reg : cur_reg[HW-1:0];

    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = handle_reg;
        next_wdata = cur_reg;
        if (cmd.ins_write)
            next_we = 1'b1;
        else if (cmd.ins_link)
        begin
            next_we    = 1'b1;
            next_waddr = prev_reg[HW-1:0];
            next_wdata = {1'b0, handle_reg};
        end
        else if (cmd.rem_unlink && !sts.prev_nil)
        begin
            next_we    = 1'b1;
            next_waddr = prev_reg[HW-1:0];
            next_wdata = rd_next_q;
        end
    end

    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = bkt_reg;
        head_wdata = handle_reg;
        if (cmd.ins_write && sts.prev_nil)
            head_we = 1'b1;
        else if (cmd.rem_unlink && sts.prev_nil)
        begin
            head_we    = 1'b1;
            head_wdata = rd_next_q[HW-1:0];
        end
        else if (cmd.min_take && is_extract)
        begin
            head_we    = 1'b1;
            head_waddr = lowest_reg;
            head_wdata = rd_next_q[HW-1:0];
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.ins_write)
        begin
            node_y_mem[handle_reg] <= y_reg;
            node_x_mem[handle_reg] <= x_reg;
        end
        if (next_we)
            node_next_mem[next_waddr] <= next_wdata;
        if (cmd.node_rd_cur || cmd.node_rd_handle)
        begin
            rd_y_q    <= node_y_mem[node_raddr];
            rd_x_q    <= node_x_mem[node_raddr];
            rd_next_q <= node_next_mem[node_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        if (cmd.head_rd)
            head_q <= head_mem[hidx];
    end

    // request, bucket index and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_reg    <= bepq_pkg::req_t'(req_type);
            handle_reg <= handle;
            y_reg      <= y_key;
            x_reg      <= x_key;
        end
        if (cmd.bk_mul)
        begin
            prod_reg  <= {{bepq_pkg::BC_W{1'b0}}, off[bepq_pkg::SPAN_W-1:0]}
                         * {{bepq_pkg::SPAN_W{1'b0}}, n_used};
            q_reg     <= '0;
            div_i_reg <= 3'(bepq_pkg::BC_W - 1);
            bkt_reg   <= off_neg ? '0 : n_last;
        end
        if (cmd.bk_div)
        begin
            prod_reg  <= prod_next;
            q_reg     <= q_next;
            div_i_reg <= div_i_reg - 3'd1;
            if (sts.div_last)
                bkt_reg <= q_next[BW-1:0];
        end
        if (cmd.cur_from_head)
        begin
            cur_reg  <= sts.head_ne ? {1'b0, head_q} : bepq_pkg::NIL_PTR;
            prev_reg <= bepq_pkg::NIL_PTR;
        end
        else if (cmd.step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_next_q;
        end
        if (cmd.min_take)
        begin
            res_handle_reg <= cur_reg[HW-1:0];
            res_y_reg      <= rd_y_q;
            res_x_reg      <= rd_x_q;
        end
    end

    // queue control state; a configuration write to index 0, 1 or 2 empties the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_origin_reg     <= '0;
            y_span_reg       <= bepq_pkg::SPAN_W'(65536);
            bucket_count_reg <= bepq_pkg::BC_W'(bepq_pkg::MAX_BUCKETS);
            present_reg      <= '0;
            nonempty_reg     <= '0;
            lowest_reg       <= '0;
            live_reg         <= '0;
            res_min_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bepq_pkg::CFG_Y_ORIGIN:     y_origin_reg <= cfg_data;
                bepq_pkg::CFG_Y_SPAN:       y_span_reg <= cfg_data[bepq_pkg::SPAN_W-1:0];
                bepq_pkg::CFG_BUCKET_COUNT: bucket_count_reg <= cfg_data[bepq_pkg::BC_W-1:0];
                default:                    y_span_reg <= y_span_reg;
            endcase
            if (cfg_index <= bepq_pkg::CFG_BUCKET_COUNT)
            begin
                present_reg  <= '0;
                nonempty_reg <= '0;
                lowest_reg   <= '0;
                live_reg     <= '0;
            end
        end
        else
        begin
            if (cmd.latch_req)
                res_min_reg <= 1'b0;
            if (cmd.min_take)
            begin
                res_min_reg <= 1'b1;
                if (is_extract)
                begin
                    nonempty_reg[lowest_reg]     <= !sts.next_nil;
                    present_reg[cur_reg[HW-1:0]] <= 1'b0;
                    live_reg                     <= live_reg - 1'b1;
                end
            end
            if (cmd.ins_write)
            begin
                present_reg[handle_reg] <= 1'b1;
                live_reg                <= live_reg + 1'b1;
                if (sts.prev_nil)
                    nonempty_reg[bkt_reg] <= 1'b1;
                if (bkt_reg < lowest_reg)
                    lowest_reg <= bkt_reg;
            end
            if (cmd.rem_unlink)
            begin
                present_reg[handle_reg] <= 1'b0;
                live_reg                <= live_reg - 1'b1;
                if (sts.prev_nil)
                    nonempty_reg[bkt_reg] <= !sts.next_nil;
            end
            if (cmd.adv_clamp && ({1'b0, lowest_reg} >= n_used))
                lowest_reg <= n_last;
            if (cmd.adv_step)
                lowest_reg <= lowest_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_load)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status      <= cmd.res_status;
            out_handle  <= res_min_reg ? res_handle_reg : '0;
            out_y       <= res_min_reg ? res_y_reg : '0;
            out_x       <= res_min_reg ? res_x_reg : '0;
            entry_count <= live_reg;
            is_empty    <= (live_reg == '0);
        end
    end

    always_comb
    begin
        sts             = '0;
        sts.req         = req_reg;
        sts.present_h   = present_reg[handle_reg];
        sts.full        = (live_reg >= bepq_pkg::CNT_W'(bepq_pkg::CAPACITY));
        sts.live_zero   = (live_reg == '0);
        sts.bk_direct   = off_neg || off_ge_span;
        sts.div_last    = (div_i_reg == 3'd0);
        sts.head_ne     = nonempty_reg[hidx];
        sts.key_greater = (y_reg > rd_y_q) || ((y_reg == rd_y_q) && (x_reg > rd_x_q));
        sts.cur_is_h    = (cur_reg == {1'b0, handle_reg});
        sts.next_nil    = (rd_next_q == bepq_pkg::NIL_PTR);
        sts.prev_nil    = (prev_reg == bepq_pkg::NIL_PTR);
        sts.adv_done    = (lowest_reg >= n_last) || nonempty_reg[lowest_reg];
        sts.out_free    = !out_valid || !out_stall;
        sts.live        = live_reg;
    end

endmodule

### src/bucketed_event_priority_queue.sv
// Top level of the bucketed event priority queue: sequencer plus datapath.
//
//  channel  direction  handshake             payload
//  in       to block   in_valid / in_stall   req_type, handle, y_key, x_key
//  out      from block out_valid / out_stall status, out_handle, out_y, out_x,
//                                            entry_count, is_empty
//  cfg      to block   cfg_we                cfg_index, cfg_data
//
// One request at a time; after acceptance, an insert or remove compares list entries one
// by one, an insert behind an entry also links it, and a key inside the range first runs
// the bit-serial bucket divider. Peek and extract skip empty buckets one by one; a
// rejected request answers without a bucket or list step. Reset empties the queue at
// once through present and occupancy bits. A result waits under out_stall while the next
// one is worked.
module bucketed_event_priority_queue
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic [bepq_pkg::HANDLE_W-1:0]       handle,
    input  logic signed [bepq_pkg::KEY_W-1:0]   y_key,
    input  logic signed [bepq_pkg::KEY_W-1:0]   x_key,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic [bepq_pkg::HANDLE_W-1:0]       out_handle,
    output logic signed [bepq_pkg::KEY_W-1:0]   out_y,
    output logic signed [bepq_pkg::KEY_W-1:0]   out_x,
    output logic [bepq_pkg::CNT_W-1:0]          entry_count,
    output logic                                is_empty,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [bepq_pkg::CFG_W-1:0]          cfg_data
);

    bepq_pkg::cmd_t cmd;
    bepq_pkg::sts_t sts;

    bepq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    bepq_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .handle      (handle),
        .y_key       (y_key),
        .x_key       (x_key),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_handle  (out_handle),
        .out_y       (out_y),
        .out_x       (out_x),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another is in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sts.live <= bepq_pkg::CNT_W'(bepq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != bepq_pkg::ST_OK) |->
        (out_handle == '0 && out_y == '0 && out_x == '0))
        else $error("failed request carries entry data");

endmodule
